@@ rtl/cpcw_pkg.sv @@
// ----------------------------------------------------------------------------
// cpcw_pkg
// Widths, fixed-point constants and rounding helper for the cyclic phase
// cubic weight pipeline.
// ----------------------------------------------------------------------------
package cpcw_pkg;

  // Field widths
  localparam int PhaseW = 19;  // Q3.16 angle
  localparam int WeightW = 18; // signed Q1.16 weight
  localparam int SegW = 2;     // quarter-cycle segment
  localparam int NumSlots = 4;

  // 2/pi in Q0.24
  localparam int KW = 24;
  localparam logic [KW-1:0] TwoOverPiQ24 = 24'd10680707;

  // Internal widths
  localparam int ProdW = PhaseW + KW;  // angle * 2/pi, Q.40
  localparam int FracW = 16;           // mu, Q0.16
  localparam int M2W = 2 * FracW;      // mu^2, Q0.32
  localparam int M3W = 3 * FracW;      // mu^3, Q0.48
  localparam int XW = 54;              // 2*w at 2^48 scale, signed

  localparam int NumStages = 5;

  // Scale points of the weight sums
  localparam int RoundShift = 33;  // 2*w*2^48 -> w*2^16
  localparam logic signed [XW-1:0] HalfBias = XW'(64'd1 << (RoundShift - 1));
  localparam logic signed [XW-1:0] TwoOne = XW'(64'd1 << 49);  // 2.0 at 2^48

  // Round 2*w (2^48 scale) to Q1.16, nearest, ties toward plus infinity
  function automatic logic signed [WeightW-1:0] round_weight(
    input logic signed [XW-1:0] x
  );
    logic signed [XW-1:0] xb;
    xb = x + HalfBias;
    return xb[RoundShift+WeightW-1:RoundShift];
  endfunction

endpackage

@@ rtl/cyclic_phase_cubic_weights_top.sv @@
// ----------------------------------------------------------------------------
// cyclic_phase_cubic_weights_top
// Catmull-Rom cubic weights for a cyclic phase: scales the angle into
// quarter cycles, splits it into segment and fraction, evaluates the four
// cubic weights and rotates them into control-point slots.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | beat payload
//  --------+-----------+---------------------------+-------------------------
//  in      | sink      | in_valid_i / in_stall_o   | phase_angle_i (Q3.16)
//  out     | source    | out_valid_o / out_stall_i | weight_slot0..3_o (Q1.16),
//          |           |                           | segment_index_o
//
//  One beat is taken every cycle while in_stall_o is low; an accepted input
//  beat reaches out_valid_o through five register stages (angle multiply,
//  mu^2, mu^3, weight sums, round and rotate), each holding one multiply or
//  the wide adds of one step.
//  Reset (rst_ni low, asynchronous) clears only the stage valid bits.
//  Each stage has its own valid bit and moves on when the stage after it is
//  empty or moving, so bubbles are squeezed out and in_stall_o rises only
//  when all five stages hold beats and out_stall_i is high.
//
module cyclic_phase_cubic_weights_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [cpcw_pkg::PhaseW-1:0]          phase_angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [cpcw_pkg::WeightW-1:0]  weight_slot0_o,
  output logic signed [cpcw_pkg::WeightW-1:0]  weight_slot1_o,
  output logic signed [cpcw_pkg::WeightW-1:0]  weight_slot2_o,
  output logic signed [cpcw_pkg::WeightW-1:0]  weight_slot3_o,
  output logic [cpcw_pkg::SegW-1:0]            segment_index_o
);

  localparam int NS = cpcw_pkg::NumStages;
  localparam int FW = cpcw_pkg::FracW;
  localparam int XW = cpcw_pkg::XW;
  localparam int SW = cpcw_pkg::SegW;

  // --------------------------------------------------------------------------
  // Flow control: per-stage valid, ready ripples back from the output.
  // --------------------------------------------------------------------------
  logic [NS-1:0] valid_q;
  logic [NS-1:0] valid_d;
  logic [NS-1:0] ready;

  always_comb begin
    ready[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign in_stall_o = !ready[0];

  always_comb begin
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: angle * 2/pi
  // --------------------------------------------------------------------------
  logic [cpcw_pkg::ProdW-1:0] prod_q;
  logic [cpcw_pkg::ProdW-1:0] prod_d;

  assign prod_d = cpcw_pkg::ProdW'(phase_angle_i) * cpcw_pkg::ProdW'(cpcw_pkg::TwoOverPiQ24);

  always_ff @(posedge clk_i) begin
    if (ready[0] && in_valid_i) begin
      prod_q <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: split t into segment and mu, square mu
  // --------------------------------------------------------------------------
  logic [FW-1:0]            mu_s1;
  logic [SW-1:0]            seg_s1;
  logic [FW-1:0]            mu1_q;
  logic [SW-1:0]            seg1_q;
  logic [cpcw_pkg::M2W-1:0] m21_q;
  logic [cpcw_pkg::M2W-1:0] m21_d;

  // t = prod >> 24; mu = t[15:0], segment = t[17:16]
  assign mu_s1  = prod_q[cpcw_pkg::KW +: FW];
  assign seg_s1 = prod_q[cpcw_pkg::KW + FW +: SW];
  assign m21_d  = cpcw_pkg::M2W'(mu_s1) * cpcw_pkg::M2W'(mu_s1);

  always_ff @(posedge clk_i) begin
    if (ready[1] && valid_q[0]) begin
      mu1_q  <= mu_s1;
      seg1_q <= seg_s1;
      m21_q  <= m21_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: cube
  // --------------------------------------------------------------------------
  logic [FW-1:0]            mu2_q;
  logic [SW-1:0]            seg2_q;
  logic [cpcw_pkg::M2W-1:0] m22_q;
  logic [cpcw_pkg::M3W-1:0] m32_q;
  logic [cpcw_pkg::M3W-1:0] m32_d;

  assign m32_d = cpcw_pkg::M3W'(m21_q) * cpcw_pkg::M3W'(mu1_q);

  always_ff @(posedge clk_i) begin
    if (ready[2] && valid_q[1]) begin
      mu2_q  <= mu1_q;
      seg2_q <= seg1_q;
      m22_q  <= m21_q;
      m32_q  <= m32_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: weight sums, 2*w at 2^48 scale
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] m3x;
  logic signed [XW-1:0] m2x;
  logic signed [XW-1:0] mux;
  logic signed [XW-1:0] x_d [cpcw_pkg::NumSlots];
  logic signed [XW-1:0] x3_q [cpcw_pkg::NumSlots];
  logic [SW-1:0]        seg3_q;

  assign m3x = signed'({{(XW - cpcw_pkg::M3W){1'b0}}, m32_q});
  assign m2x = signed'({{(XW - cpcw_pkg::M2W){1'b0}}, m22_q});
  assign mux = signed'({{(XW - FW){1'b0}}, mu2_q});

  always_comb begin
    // -mu^3 + 2mu^2 - mu
    x_d[0] = (m2x <<< 17) - m3x - (mux <<< 32);
    // 3mu^3 - 5mu^2 + 2
    x_d[1] = (m3x <<< 1) + m3x + cpcw_pkg::TwoOne - ((m2x <<< 18) + (m2x <<< 16));
    // -3mu^3 + 4mu^2 + mu
    x_d[2] = (m2x <<< 18) + (mux <<< 32) - ((m3x <<< 1) + m3x);
    // mu^3 - mu^2
    x_d[3] = m3x - (m2x <<< 16);
  end

  always_ff @(posedge clk_i) begin
    if (ready[3] && valid_q[2]) begin
      seg3_q <= seg2_q;
      for (int j = 0; j < cpcw_pkg::NumSlots; j++) begin
        x3_q[j] <= x_d[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round, rotate weight j into slot (s + j - 1) mod 4
  // --------------------------------------------------------------------------
  logic signed [cpcw_pkg::WeightW-1:0] w_rnd [cpcw_pkg::NumSlots];
  logic signed [cpcw_pkg::WeightW-1:0] slot_d [cpcw_pkg::NumSlots];
  logic signed [cpcw_pkg::WeightW-1:0] slot_q [cpcw_pkg::NumSlots];
  logic [SW-1:0]                       seg4_q;

  always_comb begin
    logic [SW-1:0] sel;
    for (int j = 0; j < cpcw_pkg::NumSlots; j++) begin
      w_rnd[j] = cpcw_pkg::round_weight(x3_q[j]);
    end
    for (int k = 0; k < cpcw_pkg::NumSlots; k++) begin
      sel = SW'(k) - seg3_q + SW'(1);
      slot_d[k] = w_rnd[sel];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[4] && valid_q[3]) begin
      seg4_q <= seg3_q;
      for (int k = 0; k < cpcw_pkg::NumSlots; k++) begin
        slot_q[k] <= slot_d[k];
      end
    end
  end

  assign out_valid_o     = valid_q[NS-1];
  assign weight_slot0_o  = slot_q[0];
  assign weight_slot1_o  = slot_q[1];
  assign weight_slot2_o  = slot_q[2];
  assign weight_slot3_o  = slot_q[3];
  assign segment_index_o = seg4_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input is held off only with a full pipe and a stalled output.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&valid_q) && out_stall_i))
    else $error("input stalled while pipeline has room");

  // An accepted beat lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted beat lost at stage 0");

  // A beat moving out of the sum stage reaches the output register.
  a_sum_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NS-2] && ready[NS-1]) |=> out_valid_o)
    else $error("beat lost between sum and output stage");

  // A stalled beat at the output stays valid with its segment index unchanged.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(segment_index_o)))
    else $error("stalled output beat dropped");

endmodule
